// ===== rtl/bta_pkg.sv =====
// Shared constants, word types and helper functions for the buddy tree allocator.
package bta_pkg;

  localparam int LOG_BLOCKS = 10;
  localparam int NODE_COUNT = (1 << (LOG_BLOCKS + 1)) - 1;
  localparam int NODE_W     = LOG_BLOCKS + 1;
  localparam int LEAF_BASE  = (1 << LOG_BLOCKS) - 1;
  // node code: order + 1, zero marks an allocated node
  localparam int ENC_W      = $clog2(LOG_BLOCKS + 2);

  localparam int BYTES_W    = 32;
  localparam int OFF_W      = 26;
  localparam int SHIFT_W    = 5;
  localparam int SIZE_W     = 6;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd16;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;
  localparam logic [ENC_W-1:0]   ENC_USED    = '0;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_NO_SPACE  = 2'd2;
  localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic               action;
    logic [BYTES_W-1:0] request_bytes;
    logic [OFF_W-1:0]   release_offset;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OFF_W-1:0] granted_offset;
  } out_word_t;

  typedef enum logic [8:0] {
    S_CLEAR   = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_SIZE    = 9'b000000100,
    S_ROOT    = 9'b000001000,
    S_DESCEND = 9'b000010000,
    S_MARK    = 9'b000100000,
    S_ASCEND  = 9'b001000000,
    S_FREE_UP = 9'b010000000,
    S_FINISH  = 9'b100000000
  } state_t;

  function automatic logic [2:0] bitlen4(input logic [3:0] x);
    logic [2:0] n;
    priority if (x[3]) n = 3'd4;
    else if (x[2])     n = 3'd3;
    else if (x[1])     n = 3'd2;
    else if (x[0])     n = 3'd1;
    else               n = 3'd0;
    return n;
  endfunction

  function automatic logic [NODE_W-1:0] parent_of(input logic [NODE_W-1:0] i);
    logic [NODE_W-1:0] d;
    d = i - NODE_W'(1);
    return {1'b0, d[NODE_W-1:1]};
  endfunction

  function automatic logic [NODE_W-1:0] sibling_of(input logic [NODE_W-1:0] i);
    return i[0] ? i + NODE_W'(1) : i - NODE_W'(1);
  endfunction

endpackage

// ===== rtl/buddy_tree_allocator_core.sv =====
// Buddy tree allocator: tree of free orders in one RAM, walked by a read-modify-write sequencer.
// Allocate: accept, a size scan by nibbles, a root read, a descent one level at a time, a mark,
// then an ascent to the root that merges the sibling orders, and a finish.
// Free: climb from the leaf to the allocated node, then ascend to the root merging buddies.
// One request at a time; a finished word waits in the output register while the next is taken.
// Reset: synchronous; then a sweep writes each node's level order, no words taken.
module buddy_tree_allocator_core
  import bta_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_word_t            in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output out_word_t           out_word,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  logic [ENC_W-1:0] mem [NODE_COUNT];
  logic [ENC_W-1:0] rd_data;
  logic             rd_en, wr_en;
  logic [NODE_W-1:0] rd_addr, wr_addr;
  logic [ENC_W-1:0]  wr_data;

  state_t state, state_next;
  logic [SHIFT_W-1:0] block_shift, sh;
  logic                is_free, is_free_next;
  logic [BYTES_W-1:0]  req_x, req_x_next;
  logic [SIZE_W-1:0]   size_n, size_n_next;
  logic [ENC_W-1:0]    order, order_next;
  logic [NODE_W-1:0]   idx, idx_next;
  logic [ENC_W-1:0]    lvl, lvl_next;
  logic [ENC_W-1:0]    cur, cur_next;
  logic [LOG_BLOCKS-1:0] boff, boff_next;
  logic [1:0]          status, status_next;
  logic [NODE_W-1:0]   clr_idx, clr_idx_next, clr_last, clr_last_next;
  logic [ENC_W-1:0]    clr_enc, clr_enc_next;

  logic [OFF_W-1:0]    blk;
  logic [SIZE_W-1:0]   nbits, ord_full;
  logic [NODE_W-1:0]   left, right, child, par;
  logic [ENC_W-1:0]    full_enc, merged;
  logic [ENC_W-1:0]    lvl_dn;
  logic                fits;
  logic [OFF_W-1:0]    off_ext, grant;

  assign sh       = (block_shift > SHIFT_MAX) ? SHIFT_MAX : block_shift;
  assign in_ready = (state == S_IDLE);
  assign pready   = 1'b1;
  assign prdata   = paddr[PADDR_W-1] ? '0 : PDATA_W'(block_shift);

  assign blk      = in_word.release_offset >> sh;
  assign nbits    = size_n + SIZE_W'(bitlen4(req_x[3:0]));
  assign ord_full = (nbits > SIZE_W'(sh)) ? nbits - SIZE_W'(sh) : '0;
  assign left     = {idx[NODE_W-2:0], 1'b1};
  assign right    = left + NODE_W'(1);
  assign fits     = (rd_data >= order + ENC_W'(1));
  assign child    = fits ? left : right;
  assign lvl_dn   = lvl - ENC_W'(1);
  assign par      = parent_of(idx);
  assign full_enc = lvl + ENC_W'(1);
  assign merged   = (is_free && cur == full_enc && rd_data == full_enc) ? lvl + ENC_W'(2) :
                    (cur > rd_data) ? cur : rd_data;
  assign off_ext  = OFF_W'(boff);
  assign grant    = off_ext << sh;

  always_comb begin
    state_next    = state;
    is_free_next  = is_free;
    req_x_next    = req_x;
    size_n_next   = size_n;
    order_next    = order;
    idx_next      = idx;
    lvl_next      = lvl;
    cur_next      = cur;
    boff_next     = boff;
    status_next   = status;
    clr_idx_next  = clr_idx;
    clr_last_next = clr_last;
    clr_enc_next  = clr_enc;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    unique case (state)
      S_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_idx;
        wr_data      = clr_enc;
        clr_idx_next = clr_idx + NODE_W'(1);
        if (clr_idx == clr_last) begin
          clr_enc_next  = clr_enc - ENC_W'(1);
          clr_last_next = {clr_last[NODE_W-2:0], 1'b0} + NODE_W'(2);
        end
        if (clr_idx == NODE_W'(NODE_COUNT - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          is_free_next = (in_word.action == ACT_FREE);
          status_next  = ST_OK;
          boff_next    = '0;
          if (in_word.action == ACT_FREE) begin
            if (|blk[OFF_W-1:LOG_BLOCKS]) begin
              status_next = ST_NOT_ALLOC;
              state_next  = S_FINISH;
            end else begin
              idx_next   = NODE_W'(blk[LOG_BLOCKS-1:0]) + NODE_W'(LEAF_BASE);
              rd_en      = 1'b1;
              rd_addr    = idx_next;
              lvl_next   = '0;
              state_next = S_FREE_UP;
            end
          end else begin
            req_x_next  = (in_word.request_bytes == '0) ? '0 :
                          in_word.request_bytes - BYTES_W'(1);
            size_n_next = '0;
            state_next  = S_SIZE;
          end
        end
      end
      S_SIZE: begin
        if (|req_x[BYTES_W-1:4]) begin
          req_x_next  = req_x >> 4;
          size_n_next = size_n + SIZE_W'(4);
        end else if (ord_full > SIZE_W'(LOG_BLOCKS)) begin
          status_next = ST_TOO_LARGE;
          state_next  = S_FINISH;
        end else begin
          order_next = ENC_W'(ord_full);
          rd_en      = 1'b1;
          rd_addr    = '0;
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        idx_next = '0;
        lvl_next = ENC_W'(LOG_BLOCKS);
        if (rd_data < order + ENC_W'(1)) begin
          status_next = ST_NO_SPACE;
          state_next  = S_FINISH;
        end else if (order == ENC_W'(LOG_BLOCKS)) begin
          state_next = S_MARK;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = NODE_W'(1);
          state_next = S_DESCEND;
        end
      end
      S_DESCEND: begin
        idx_next = child;
        lvl_next = lvl_dn;
        if (!fits) boff_next = boff | (LOG_BLOCKS'(1) << lvl_dn);
        if (lvl_dn == order) begin
          state_next = S_MARK;
        end else begin
          rd_en   = 1'b1;
          rd_addr = {child[NODE_W-2:0], 1'b1};
        end
      end
      S_MARK: begin
        wr_en    = 1'b1;
        wr_addr  = idx;
        wr_data  = ENC_USED;
        cur_next = ENC_USED;
        if (idx == '0) begin
          state_next = S_FINISH;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = sibling_of(idx);
          state_next = S_ASCEND;
        end
      end
      S_ASCEND: begin
        wr_en    = 1'b1;
        wr_addr  = par;
        wr_data  = merged;
        cur_next = merged;
        idx_next = par;
        lvl_next = lvl + ENC_W'(1);
        if (par == '0) begin
          state_next = S_FINISH;
        end else begin
          rd_en   = 1'b1;
          rd_addr = sibling_of(par);
        end
      end
      S_FREE_UP: begin
        if (rd_data == ENC_USED) begin
          wr_en    = 1'b1;
          wr_addr  = idx;
          wr_data  = lvl + ENC_W'(1);
          cur_next = lvl + ENC_W'(1);
          if (idx == '0) begin
            state_next = S_FINISH;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = sibling_of(idx);
            state_next = S_ASCEND;
          end
        end else if (idx == '0) begin
          status_next = ST_NOT_ALLOC;
          state_next  = S_FINISH;
        end else begin
          idx_next = par;
          lvl_next = lvl + ENC_W'(1);
          rd_en    = 1'b1;
          rd_addr  = par;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      block_shift <= SHIFT_RESET;
      clr_idx     <= '0;
      clr_last    <= '0;
      clr_enc     <= ENC_W'(LOG_BLOCKS + 1);
      out_valid   <= 1'b0;
    end else begin
      state    <= state_next;
      clr_idx  <= clr_idx_next;
      clr_last <= clr_last_next;
      clr_enc  <= clr_enc_next;
      if (psel && penable && pwrite && !paddr[PADDR_W-1]) block_shift <= pwdata[SHIFT_W-1:0];
      if (state == S_FINISH && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    is_free <= is_free_next;
    req_x   <= req_x_next;
    size_n  <= size_n_next;
    order   <= order_next;
    idx     <= idx_next;
    lvl     <= lvl_next;
    cur     <= cur_next;
    boff    <= boff_next;
    status  <= status_next;
    if (state == S_FINISH && (!out_valid || out_ready)) begin
      out_word.status         <= status;
      out_word.granted_offset <= (status == ST_OK && !is_free) ? grant : '0;
    end
  end

endmodule

// ===== tb/tb_buddy_tree_allocator_core.sv =====
// Self-checking testbench for the buddy tree allocator core with its own tree model.
module tb_buddy_tree_allocator_core;
  import bta_pkg::*;

  localparam logic [PADDR_W-1:0] ADDR_BLOCK_SHIFT = 3'd0;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = 48;
  localparam int PHASE_ITEMS = 175;
  localparam int USED = -1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_word;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  buddy_tree_allocator_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // tree of free orders, USED where a node is allocated
  int node_order [NODE_COUNT];
  int unsigned shift_setting = SHIFT_RESET;
  int live_blk[$];
  int live_ord[$];
  out_word_t pending_replies[$];
  out_word_t head_reply;
  int mismatch_count = 0;
  int unsigned cycle_count = 0;
  int burst_left = 0;
  bit steady = 1'b0;
  int rx_mode = 0;
  int rx_left = 0;

  function automatic int block_bits();
    return (shift_setting > SHIFT_MAX) ? int'(SHIFT_MAX) : int'(shift_setting);
  endfunction

  function automatic int larger(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  function automatic void tree_init();
    node_order[0] = LOG_BLOCKS;
    for (int i = 1; i < NODE_COUNT; i++) node_order[i] = node_order[(i - 1) >> 1] - 1;
  endfunction

  function automatic out_word_t grant_region(input logic [BYTES_W-1:0] bytes);
    out_word_t r;
    longint unsigned span_mask, blocks, first;
    int sh, ord, lvl, idx;
    r = '0;
    r.status = ST_OK;
    sh = block_bits();
    span_mask = (64'd1 << sh) - 64'd1;
    blocks = ({32'd0, bytes} + span_mask) >> sh;
    if (blocks == 0) blocks = 1;
    ord = 0;
    while ((64'd1 << ord) < blocks) ord++;
    if (ord > LOG_BLOCKS) begin
      r.status = ST_TOO_LARGE;
    end else if (node_order[0] < ord) begin
      r.status = ST_NO_SPACE;
    end else begin
      idx = 0;
      for (lvl = LOG_BLOCKS; lvl > ord; lvl--) begin
        idx = 2 * idx + 1;
        if (node_order[idx] < ord) idx++;
      end
      node_order[idx] = USED;
      first = ((64'(idx) + 64'd1) << ord) - (64'd1 << LOG_BLOCKS);
      live_blk.push_back(int'(first));
      live_ord.push_back(ord);
      r.granted_offset = OFF_W'(first << sh);
      while (idx != 0) begin
        idx = (idx - 1) >> 1;
        node_order[idx] = larger(node_order[2 * idx + 1], node_order[2 * idx + 2]);
      end
    end
    return r;
  endfunction

  function automatic out_word_t release_region(input logic [OFF_W-1:0] off);
    out_word_t r;
    int blk, idx, n, base, lft, rgt;
    r = '0;
    r.status = ST_NOT_ALLOC;
    blk = int'(off >> block_bits());
    if (blk >= (1 << LOG_BLOCKS)) return r;
    idx = blk + LEAF_BASE;
    n = 0;
    while (node_order[idx] != USED) begin
      if (idx == 0) return r;
      idx = (idx - 1) >> 1;
      n++;
    end
    node_order[idx] = n;
    base = ((idx + 1) << n) - (1 << LOG_BLOCKS);
    for (int k = 0; k < live_blk.size(); k++) begin
      if (live_blk[k] == base && live_ord[k] == n) begin
        live_blk.delete(k);
        live_ord.delete(k);
        break;
      end
    end
    while (idx != 0) begin
      idx = (idx - 1) >> 1;
      n++;
      lft = node_order[2 * idx + 1];
      rgt = node_order[2 * idx + 2];
      if (lft == n - 1 && rgt == n - 1) node_order[idx] = n;
      else node_order[idx] = larger(lft, rgt);
    end
    r.status = ST_OK;
    return r;
  endfunction

  function automatic logic [BYTES_W-1:0] random_bytes();
    int sh, ord, r;
    longint unsigned lo, hi;
    sh = block_bits();
    r = $urandom_range(0, 99);
    if (r >= 97) return $urandom;
    if (r < 50) ord = $urandom_range(0, 2);
    else if (r < 85) ord = $urandom_range(3, 6);
    else ord = $urandom_range(7, LOG_BLOCKS + 1);
    hi = (64'd1 << ord) << sh;
    lo = (ord == 0) ? 64'd0 : (hi >> 1) + 64'd1;
    return $urandom_range(32'(hi), 32'(lo));
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch: %s expected %0h got %0h at cycle %0d", what, want, got, cycle_count);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected word", 0, out_word);
      end else begin
        head_reply = pending_replies.pop_front();
        if (out_word.status !== head_reply.status)
          report_mismatch("status", head_reply.status, out_word.status);
        if (out_word.granted_offset !== head_reply.granted_offset)
          report_mismatch("granted_offset", head_reply.granted_offset, out_word.granted_offset);
      end
    end
  end

  // receiver back-pressure: modes of free flow, coin toss, long stalls, toggling
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= $urandom_range(0, 1);
      end
      2: begin
        out_ready <= ($urandom_range(0, 7) == 0);
      end
      default: begin
        out_ready <= ~out_ready;
      end
    endcase
  end

  task automatic send_word(input in_word_t w);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    if (w.action == ACT_FREE) pending_replies.push_back(release_region(w.release_offset));
    else pending_replies.push_back(grant_region(w.request_bytes));
  endtask

  task automatic alloc_item(input logic [BYTES_W-1:0] bytes);
    in_word_t w;
    w.action = ACT_ALLOC;
    w.request_bytes = bytes;
    w.release_offset = OFF_W'($urandom);
    send_word(w);
  endtask

  task automatic free_item(input logic [OFF_W-1:0] off);
    in_word_t w;
    w.action = ACT_FREE;
    w.request_bytes = $urandom;
    w.release_offset = off;
    send_word(w);
  endtask

  // free a live region through a random address inside it
  task automatic free_live();
    int k, sh;
    longint unsigned span;
    sh = block_bits();
    k = $urandom_range(0, live_blk.size() - 1);
    span = (64'd1 << live_ord[k]) << sh;
    free_item(OFF_W'((longint'(live_blk[k]) << sh) + $urandom_range(32'(span - 1), 0)));
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_replies_drained();
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_block_shift(input int unsigned value);
    idle_input();
    wait_replies_drained();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_BLOCK_SHIFT;
    pwdata <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shift_setting = value & 32'h1F;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic test_default_shift();
    alloc_item(32'd0);
    alloc_item(32'd1);
    alloc_item(32'd4097);
    alloc_item(32'hFFFF_FFFF);
    alloc_item(32'h0040_0000);
    free_item(26'h0002FFF);
    free_item(26'h0002000);
    free_item(26'h3FFFFFF);
    free_item(26'h0000000);
    free_item(26'h0001000);
    alloc_item(32'h0040_0000);
    free_item(26'h03FF000);
  endtask

  task automatic test_shift_extremes();
    write_block_shift(0);
    alloc_item(32'd1024);
    alloc_item(32'd0);
    alloc_item(32'd1025);
    free_item(26'd513);
    write_block_shift(16);
    alloc_item(32'h03FF_0001);
    free_item(26'h3FFFFFF);
    alloc_item(32'h0001_0000);
    alloc_item(32'd1);
    write_block_shift(31);
    alloc_item(32'd1);
    free_item(26'h0010000);
    free_item(26'h0020005);
    free_item(26'h0000000);
  endtask

  task automatic test_random_mix();
    int unsigned settings[6];
    int r;
    settings[0] = 12;
    settings[1] = 0;
    settings[2] = 16;
    settings[3] = 31;
    settings[4] = $urandom_range(1, 15);
    settings[5] = $urandom_range(17, 30);
    for (int p = 0; p < 6; p++) begin
      write_block_shift(settings[p]);
      steady = (p == 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == 80) begin
          idle_input();
          wait_replies_drained();
        end
        r = $urandom_range(0, 99);
        if (live_blk.size() == 0 || r < 55) alloc_item(random_bytes());
        else if (r < 88) free_live();
        else if (r < 94) free_item(OFF_W'($urandom));
        else free_item(OFF_W'($urandom_range((1 << (LOG_BLOCKS + block_bits())) - 1, 0)));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    tree_init();
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_default_shift();
    test_shift_extremes();
    test_random_mix();
    write_block_shift(SHIFT_RESET);
    idle_input();
    wait_replies_drained();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
